[rtl/core/bpc_pkg.sv]
`timescale 1ns / 1ps

package bpc_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4
  } reg_idx_t;

  localparam logic [31:0] RST_AC1_AC2 = 32'h203A_FB6D;
  localparam logic [31:0] RST_AC3_AC4 = 32'hC6F7_836D;
  localparam logic [31:0] RST_AC5_AC6 = 32'h63E7_3EAA;
  localparam logic [31:0] RST_B1_B2   = 32'h1973_002E;
  localparam logic [31:0] RST_MC_MD   = 32'hD1F6_09A6;

  // quotient bits of the temperature divider (|MC| * 2048 <= 2^26)
  localparam int TDIV_BITS = 27;
  // quotient bits of the pressure divider
  localparam int PDIV_BITS = 32;
  // B4 is a 17-bit value
  localparam int B4_BITS = 17;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
  localparam logic [31:0] B4_OFFSET = 32'd32768;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic signed [31:0] P_SQ_COEF  = 32'sd3038;
  localparam logic signed [31:0] P_LIN_COEF = -32'sd7357;
  localparam logic signed [31:0] P_BIAS     = 32'sd3791;

  typedef logic signed [31:0] sword_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  // request passed from the temperature front to the pressure back
  typedef struct packed {
    sword_t      b5;
    sword_t      t;
    logic [15:0] up;
    logic        err;
  } treq_t;

  // signed division by 2^k, truncating toward zero
  function automatic sword_t sdiv_pow2(input sword_t x, input int k);
    logic [31:0] bias;
    logic [31:0] sum;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    sum  = 32'(x) + bias;
    return $signed(sum) >>> k;
  endfunction

endpackage

[rtl/core/barometric_pressure_compensation.sv]
`timescale 1ns / 1ps
// Throughput: one request per cycle unless in_stall or out_stall holds the flow; every
// stage, the one-bit-per-stage dividers included (27 stages for the temperature divisor,
// 32 for B4), takes a new request each cycle.
// A four-entry queue parts the temperature front from the pressure back.
// Reset (rst_n, synchronous, active low) empties the pipeline and the queue
// and loads the calibration registers with their default coefficients.

module barometric_pressure_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_raw_temperature,
  input  logic [15:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_temperature_tenths,
  output logic signed [31:0] out_pressure_pascal,
  output logic               out_divide_error
);

  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  bpc_pkg::cal_t  cal;
  bpc_pkg::treq_t wdata, rdata;
  logic push, pop, full, empty;

  // write the calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= bpc_pkg::RST_AC1_AC2;
      ac34_r <= bpc_pkg::RST_AC3_AC4;
      ac56_r <= bpc_pkg::RST_AC5_AC6;
      b12_r  <= bpc_pkg::RST_B1_B2;
      mcmd_r <= bpc_pkg::RST_MC_MD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::REG_AC1_AC2: ac12_r <= cfg_wdata;
        bpc_pkg::REG_AC3_AC4: ac34_r <= cfg_wdata;
        bpc_pkg::REG_AC5_AC6: ac56_r <= cfg_wdata;
        bpc_pkg::REG_B1_B2:   b12_r  <= cfg_wdata;
        bpc_pkg::REG_MC_MD:   mcmd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack the coefficients
  always_comb begin
    cal.ac1 = $signed(ac12_r[31:16]);
    cal.ac2 = $signed(ac12_r[15:0]);
    cal.ac3 = $signed(ac34_r[31:16]);
    cal.ac4 = ac34_r[15:0];
    cal.ac5 = ac56_r[31:16];
    cal.ac6 = ac56_r[15:0];
    cal.b1  = $signed(b12_r[31:16]);
    cal.b2  = $signed(b12_r[15:0]);
    cal.mc  = $signed(mcmd_r[31:16]);
    cal.md  = $signed(mcmd_r[15:0]);
  end

  bpc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .cal                (cal),
    .fifo_full          (full),
    .fifo_push          (push),
    .fifo_wdata         (wdata)
  );

  bpc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .full  (full),
    .empty (empty)
  );

  bpc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cal                    (cal),
    .fifo_empty             (empty),
    .fifo_rdata             (rdata),
    .fifo_pop               (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_temperature_tenths (out_temperature_tenths),
    .out_pressure_pascal    (out_pressure_pascal),
    .out_divide_error       (out_divide_error)
  );

endmodule

[rtl/core/bpc_front.sv]
`timescale 1ns / 1ps

module bpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_raw_temperature,
  input  logic [15:0]       in_raw_pressure,
  input  bpc_pkg::cal_t     cal,
  input  logic              fifo_full,
  output logic              fifo_push,
  output bpc_pkg::treq_t    fifo_wdata
);

  typedef struct packed {
    logic [15:0]                      up;
    bpc_pkg::sword_t                  x1;
    logic [31:0]                      dmag;
    logic                             neg;
    logic                             err;
    logic [31:0]                      rem;
    logic [bpc_pkg::TDIV_BITS-1:0]    n;
    logic [bpc_pkg::TDIV_BITS-1:0]    q;
  } fr_t;

  logic en;
  logic va_r;
  fr_t  sa_r, sa_nxt;
  logic vd_r [0:bpc_pkg::TDIV_BITS];
  fr_t  dv_r [0:bpc_pkg::TDIV_BITS];
  fr_t  sb_nxt;
  logic vc_r;
  bpc_pkg::treq_t sc_r, sc_nxt;

  // advance unless the finished request cannot enter the queue
  assign en         = !(vc_r && fifo_full);
  assign in_stall   = !en;
  assign fifo_push  = vc_r && !fifo_full;
  assign fifo_wdata = sc_r;

  // stage A: (UT - AC6) * AC5
  always_comb begin
    sa_nxt    = '0;
    sa_nxt.up = in_raw_pressure;
    sa_nxt.x1 = ($signed({16'd0, in_raw_temperature}) - $signed({16'd0, cal.ac6}))
                * $signed({16'd0, cal.ac5});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= sa_nxt;
    end
  end

  // stage B: X1, divisor X1 + MD, magnitudes for the divider
  always_comb begin
    bpc_pkg::sword_t x1;
    bpc_pkg::sword_t den;
    logic [15:0]     mabs;
    x1   = bpc_pkg::sdiv_pow2(sa_r.x1, 15);
    den  = x1 + 32'(cal.md);
    mabs = cal.mc[15] ? 16'(-cal.mc) : 16'(cal.mc);
    sb_nxt      = sa_r;
    sb_nxt.x1   = x1;
    sb_nxt.err  = (den == 32'sd0);
    sb_nxt.neg  = den[31] ^ cal.mc[15];
    sb_nxt.dmag = den[31] ? 32'(-den) : 32'(den);
    sb_nxt.rem  = '0;
    sb_nxt.n    = {mabs, 11'd0};
    sb_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= sb_nxt;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < bpc_pkg::TDIV_BITS; i++) begin : g_div
    fr_t        nx;
    logic [32:0] r2;
    logic        ge;

    always_comb begin
      r2 = {dv_r[i].rem, dv_r[i].n[bpc_pkg::TDIV_BITS-1]};
      ge = (r2 >= {1'b0, dv_r[i].dmag});
      nx     = dv_r[i];
      nx.rem = ge ? 32'(r2 - {1'b0, dv_r[i].dmag}) : r2[31:0];
      nx.n   = dv_r[i].n << 1;
      nx.q   = {dv_r[i].q[bpc_pkg::TDIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[i+1] <= 1'b0;
      end else if (en) begin
        vd_r[i+1] <= vd_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[i+1] <= nx;
      end
    end
  end

  // stage C: B5 = X1 + X2 and the temperature
  always_comb begin
    bpc_pkg::sword_t qs;
    bpc_pkg::sword_t b5;
    qs  = $signed(32'(dv_r[bpc_pkg::TDIV_BITS].q));
    b5  = dv_r[bpc_pkg::TDIV_BITS].x1 + (dv_r[bpc_pkg::TDIV_BITS].neg ? -qs : qs);
    sc_nxt.b5  = b5;
    sc_nxt.t   = bpc_pkg::sdiv_pow2(b5 + 32'sd8, 4);
    sc_nxt.up  = dv_r[bpc_pkg::TDIV_BITS].up;
    sc_nxt.err = dv_r[bpc_pkg::TDIV_BITS].err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vd_r[bpc_pkg::TDIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= sc_nxt;
    end
  end

endmodule

[rtl/core/bpc_fifo.sv]
`timescale 1ns / 1ps

module bpc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bpc_pkg::treq_t  wdata,
  input  logic            pop,
  output bpc_pkg::treq_t  rdata,
  output logic            full,
  output logic            empty
);

  bpc_pkg::treq_t             mem_r [0:bpc_pkg::FIFO_DEPTH-1];
  logic [bpc_pkg::FIFO_AW-1:0] wptr_r, rptr_r;
  logic [bpc_pkg::FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (bpc_pkg::FIFO_AW+1)'(bpc_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  // track occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  // store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("request popped from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r[bpc_pkg::FIFO_AW-1:0] == bpc_pkg::FIFO_AW'(wptr_r - rptr_r))
    else $error("queue count disagrees with pointers");
`endif

endmodule

[rtl/core/bpc_back.sv]
`timescale 1ns / 1ps

module bpc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bpc_pkg::cal_t   cal,
  input  logic            fifo_empty,
  input  bpc_pkg::treq_t  fifo_rdata,
  output logic            fifo_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic signed [31:0] out_temperature_tenths,
  output logic signed [31:0] out_pressure_pascal,
  output logic            out_divide_error
);

  localparam int NPRE = 8;
  localparam int NDIV = bpc_pkg::PDIV_BITS;
  localparam int NALL = NPRE + NDIV + 3;

  typedef struct packed {
    bpc_pkg::sword_t              t;
    logic [15:0]                  up;
    logic                         err;
    bpc_pkg::sword_t              b6;
    bpc_pkg::sword_t              sq;
    bpc_pkg::sword_t              pa;
    bpc_pkg::sword_t              pb;
    bpc_pkg::sword_t              pc;
    bpc_pkg::sword_t              b3;
    bpc_pkg::sword_t              x3b;
    logic [bpc_pkg::B4_BITS-1:0]  b4;
    logic [31:0]                  diff;
    logic [31:0]                  b7;
    logic                         big;
    logic [31:0]                  num;
    logic [31:0]                  q;
    logic [bpc_pkg::B4_BITS-1:0]  rem;
    bpc_pkg::sword_t              p;
    bpc_pkg::sword_t              p8;
    bpc_pkg::sword_t              m;
    bpc_pkg::sword_t              sqr;
  } bk_t;

  logic en;
  logic v_r  [0:NALL-1];
  bk_t  s_r  [0:NALL-1];
  bk_t  s_nxt[0:NALL-1];
  logic out_valid_r;
  logic signed [31:0] tout_r, pout_r;
  logic err_r;
  bpc_pkg::sword_t tout_nxt, pout_nxt;
  logic err_nxt;

  // hold everything while the result waits
  assign en       = !(out_valid_r && out_stall);
  assign fifo_pop = en && !fifo_empty;

  // stage 0: B6
  always_comb begin
    s_nxt[0]     = '0;
    s_nxt[0].t   = fifo_rdata.t;
    s_nxt[0].up  = fifo_rdata.up;
    s_nxt[0].err = fifo_rdata.err;
    s_nxt[0].b6  = fifo_rdata.b5 - bpc_pkg::B6_OFFSET;
  end

  // stage 1: B6^2, AC2*B6, AC3*B6
  always_comb begin
    s_nxt[1]    = s_r[0];
    s_nxt[1].sq = s_r[0].b6 * s_r[0].b6;
    s_nxt[1].pa = 32'(cal.ac2) * s_r[0].b6;
    s_nxt[1].pb = 32'(cal.ac3) * s_r[0].b6;
  end

  // stage 2: scale the products
  always_comb begin
    s_nxt[2]    = s_r[1];
    s_nxt[2].sq = bpc_pkg::sdiv_pow2(s_r[1].sq, 12);
    s_nxt[2].pa = bpc_pkg::sdiv_pow2(s_r[1].pa, 11);
    s_nxt[2].pb = bpc_pkg::sdiv_pow2(s_r[1].pb, 13);
  end

  // stage 3: B2*SQ into pc, B1*SQ into sq
  always_comb begin
    s_nxt[3]    = s_r[2];
    s_nxt[3].pc = 32'(cal.b2) * s_r[2].sq;
    s_nxt[3].sq = 32'(cal.b1) * s_r[2].sq;
  end

  // stage 4: B3 and the second X3
  always_comb begin
    bpc_pkg::sword_t x1, x3, x2;
    x1 = bpc_pkg::sdiv_pow2(s_r[3].pc, 11);
    x3 = x1 + s_r[3].pa;
    x2 = bpc_pkg::sdiv_pow2(s_r[3].sq, 16);
    s_nxt[4]     = s_r[3];
    s_nxt[4].b3  = bpc_pkg::sdiv_pow2((32'(cal.ac1) <<< 2) + x3 + 32'sd2, 2);
    s_nxt[4].x3b = bpc_pkg::sdiv_pow2(s_r[3].pb + x2 + 32'sd2, 2);
  end

  // stage 5: B4 and UP - B3
  always_comb begin
    logic [31:0] u, prod;
    u    = 32'(s_r[4].x3b) + bpc_pkg::B4_OFFSET;
    prod = {16'd0, cal.ac4} * u;
    s_nxt[5]      = s_r[4];
    s_nxt[5].b4   = prod[31:15];
    s_nxt[5].diff = {16'd0, s_r[4].up} - 32'(s_r[4].b3);
  end

  // stage 6: B7
  always_comb begin
    s_nxt[6]     = s_r[5];
    s_nxt[6].b7  = s_r[5].diff * bpc_pkg::B7_SCALE;
    s_nxt[6].err = s_r[5].err || (s_r[5].b4 == '0);
  end

  // stage 7: pick the dividend
  always_comb begin
    s_nxt[7]     = s_r[6];
    s_nxt[7].big = s_r[6].b7[31];
    s_nxt[7].num = s_r[6].b7[31] ? s_r[6].b7 : {s_r[6].b7[30:0], 1'b0};
    s_nxt[7].q   = '0;
    s_nxt[7].rem = '0;
  end

  // restoring divider by B4, one bit per stage
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    logic [bpc_pkg::B4_BITS:0] r2;
    logic                      ge;
    always_comb begin
      r2 = {s_r[NPRE-1+i].rem, s_r[NPRE-1+i].num[31]};
      ge = (r2 >= {1'b0, s_r[NPRE-1+i].b4});
      s_nxt[NPRE+i]     = s_r[NPRE-1+i];
      s_nxt[NPRE+i].rem = ge ? bpc_pkg::B4_BITS'(r2 - {1'b0, s_r[NPRE-1+i].b4})
                             : r2[bpc_pkg::B4_BITS-1:0];
      s_nxt[NPRE+i].num = s_r[NPRE-1+i].num << 1;
      s_nxt[NPRE+i].q   = {s_r[NPRE-1+i].q[30:0], ge};
    end
  end

  // quotient to pressure, P/256 and -7357*P
  always_comb begin
    bpc_pkg::sword_t p;
    p = s_r[NPRE+NDIV-1].big ? $signed({s_r[NPRE+NDIV-1].q[30:0], 1'b0})
                             : $signed(s_r[NPRE+NDIV-1].q);
    s_nxt[NPRE+NDIV]    = s_r[NPRE+NDIV-1];
    s_nxt[NPRE+NDIV].p  = p;
    s_nxt[NPRE+NDIV].p8 = bpc_pkg::sdiv_pow2(p, 8);
    s_nxt[NPRE+NDIV].m  = bpc_pkg::P_LIN_COEF * p;
  end

  // square of P/256
  always_comb begin
    s_nxt[NPRE+NDIV+1]     = s_r[NPRE+NDIV];
    s_nxt[NPRE+NDIV+1].sqr = s_r[NPRE+NDIV].p8 * s_r[NPRE+NDIV].p8;
  end

  // times 3038
  always_comb begin
    s_nxt[NPRE+NDIV+2]     = s_r[NPRE+NDIV+1];
    s_nxt[NPRE+NDIV+2].sqr = s_r[NPRE+NDIV+1].sqr * bpc_pkg::P_SQ_COEF;
  end

  // final correction of the pressure
  always_comb begin
    bpc_pkg::sword_t x1, x2, s;
    x1 = bpc_pkg::sdiv_pow2(s_r[NPRE+NDIV+2].sqr, 16);
    x2 = bpc_pkg::sdiv_pow2(s_r[NPRE+NDIV+2].m, 16);
    s  = x1 + x2 + bpc_pkg::P_BIAS;
    err_nxt  = s_r[NPRE+NDIV+2].err;
    tout_nxt = err_nxt ? 32'sd0 : s_r[NPRE+NDIV+2].t;
    pout_nxt = err_nxt ? 32'sd0 : s_r[NPRE+NDIV+2].p + bpc_pkg::sdiv_pow2(s, 4);
  end

  // pipeline registers
  for (genvar j = 0; j < NALL; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= (j == 0) ? !fifo_empty : v_r[(j == 0) ? 0 : j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j] <= s_nxt[j];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NPRE+NDIV+2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tout_r <= tout_nxt;
      pout_r <= pout_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_temperature_tenths = tout_r;
  assign out_pressure_pascal    = pout_r;
  assign out_divide_error       = err_r;

endmodule
